@@ hw/rtl/cibp_pkg.sv @@
// Shared types, command codes and sizes for the compressed integer bit packer.
package cibp_pkg;

    // Input command codes
    localparam logic [2:0] CMD_BIT   = 3'd0;
    localparam logic [2:0] CMD_BYTE  = 3'd1;
    localparam logic [2:0] CMD_HALF  = 3'd2;
    localparam logic [2:0] CMD_C32   = 3'd3;
    localparam logic [2:0] CMD_C64   = 3'd4;
    localparam logic [2:0] CMD_FLUSH = 3'd5;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int NBITS_W = 4;

    // Segment word: longest item is 6 header bits plus 64 data bits
    localparam int SEG_W = 72;
    localparam int LEN_W = 7;

    // Default depth of the queue between front and back (at least 2)
    localparam int QUEUE_DEPTH = 2;

    // One classified item: MSB-aligned bit string, zero beyond its length
    typedef struct packed {
        logic             flush;
        logic [SEG_W-1:0] bits;
        logic [LEN_W-1:0] len;
    } t_seg;

endpackage

@@ hw/rtl/cibp_if.sv @@
// Valid/ready channel interfaces for the input items and the packed stream bytes.
interface cibp_in_if import cibp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;

    modport src (output valid, cmd, value, input ready);
    modport snk (input valid, cmd, value, output ready);
endinterface

interface cibp_out_if import cibp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic [NBITS_W-1:0] valid_bits;
    logic               last;

    modport src (output valid, out_byte, valid_bits, last, input ready);
    modport snk (input valid, out_byte, valid_bits, last, output ready);
endinterface

@@ hw/rtl/cibp_front.sv @@
// Front end: classifies an input item and builds its MSB-aligned bit segment.
module cibp_front import cibp_pkg::*; (
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_keep,
    output t_seg               o_seg
);

    logic [VALUE_W-1:0] x;
    logic               sign;
    logic [7:0]         sbyte;
    logic [2:0]         t;
    logic               found;
    logic               half;
    logic [63:0]        d;
    logic [2:0]         cnt3;
    logic [LEN_W-1:0]   dlen;

    // Sign-extend the 32-bit case so one search serves both sizes
    assign x     = (i_cmd == CMD_C32) ? {{32{i_value[31]}}, i_value[31:0]} : i_value;
    assign sign  = x[63];
    assign sbyte = {8{sign}};

    // Find the highest byte that differs from the sign byte
    always_comb begin
        t     = '0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (x[8*i +: 8] != sbyte) begin
                t     = 3'(i);
                found = 1'b1;
            end
        end
    end

    // Half flag: upper nibble of the first non-sign byte equals the sign nibble
    assign half = found && (x[{t, 3'b100} +: 4] == {4{sign}});
    assign cnt3 = 3'd7 - t;
    assign dlen = LEN_W'({1'b0, t, 3'b000}) + (half ? LEN_W'(4) : LEN_W'(8));

    // Lay bytes out low byte first, cut the top one, zero the sign bytes
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (3'(i) > t) begin
                d[63-8*i -: 8] = 8'h00;
            end else if (3'(i) == t && half) begin
                d[63-8*i -: 8] = {x[8*i +: 4], 4'h0};
            end else begin
                d[63-8*i -: 8] = x[8*i +: 8];
            end
        end
    end

    // Assemble the segment per command
    always_comb begin
        o_keep     = 1'b1;
        o_seg      = '0;
        case (i_cmd)
            CMD_BIT: begin
                o_seg.bits = {i_value[0], 71'b0};
                o_seg.len  = LEN_W'(1);
            end
            CMD_BYTE: begin
                o_seg.bits = {i_value[7:0], 64'b0};
                o_seg.len  = LEN_W'(8);
            end
            CMD_HALF: begin
                o_seg.bits = {i_value[7:0], i_value[15:8], 56'b0};
                o_seg.len  = LEN_W'(16);
            end
            CMD_C32: begin
                if (!found) begin
                    o_seg.bits = {sign, 1'b1, 70'b0};
                    o_seg.len  = LEN_W'(2);
                end else begin
                    o_seg.bits = {sign, 1'b0, cnt3[1:0], half, d, 3'b0};
                    o_seg.len  = dlen + LEN_W'(5);
                end
            end
            CMD_C64: begin
                if (!found) begin
                    o_seg.bits = {sign, 1'b1, 70'b0};
                    o_seg.len  = LEN_W'(2);
                end else begin
                    o_seg.bits = {sign, 1'b0, cnt3, half, d, 2'b0};
                    o_seg.len  = dlen + LEN_W'(6);
                end
            end
            CMD_FLUSH: begin
                o_seg.flush = 1'b1;
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/cibp_queue.sv @@
// Short segment queue between the front and back ends.
module cibp_queue import cibp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_seg i_seg,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_seg o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_seg             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_seg;
        end
    end

endmodule

@@ hw/rtl/cibp_back.sv @@
// Back end: merges segments with pending bits; one byte per cycle unless stalled.
module cibp_back import cibp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  t_seg           i_head,
    output logic           o_pop,
    cibp_out_if.src        o_out
);

    logic [6:0]        r_pend;
    logic [2:0]        r_cnt;
    logic              r_act;
    logic [SEG_W-1:0]  r_seg;
    logic [LEN_W-1:0]  r_rem;
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic [NBITS_W-1:0] r_obits;
    logic              r_olast;

    logic              can_load, step, cur_flush;
    logic [SEG_W-1:0]  cur_seg;
    logic [LEN_W-1:0]  cur_rem, sum, rem_after;
    logic [SEG_W+7:0]  w;
    logic              emit, fin;
    logic              out_load;

    // Select the active remainder or the queue head
    assign cur_seg   = r_act ? r_seg : i_head.bits;
    assign cur_rem   = r_act ? r_rem : i_head.len;
    assign cur_flush = !r_act && i_head.flush;

    // Window: left-aligned pending bits followed by the segment
    assign w         = {r_pend, 73'b0} | ({cur_seg, 8'b0} >> r_cnt);
    assign sum       = LEN_W'(r_cnt) + cur_rem;
    assign emit      = (sum >= LEN_W'(8));
    assign fin       = (sum < LEN_W'(16));
    assign rem_after = sum - LEN_W'(8);

    assign can_load  = !r_ovalid || o_out.ready;
    assign step      = (r_act || i_q_valid) && can_load;
    assign o_pop     = step && (cur_flush || !emit || fin);
    assign out_load  = step && (cur_flush ? (r_cnt != '0) : emit);

    // Advance packing state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_cnt    <= '0;
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (step) begin
                if (cur_flush) begin
                    if (r_cnt != '0) begin
                        r_obyte  <= {r_pend, 1'b0};
                        r_obits  <= NBITS_W'(r_cnt);
                        r_olast  <= 1'b1;
                    end
                    r_pend <= '0;
                    r_cnt  <= '0;
                end else if (emit) begin
                    r_obyte  <= w[SEG_W+7 -: 8];
                    r_obits  <= NBITS_W'(8);
                    r_olast  <= fin;
                    if (fin) begin
                        r_pend <= w[SEG_W-1 -: 7];
                        r_cnt  <= rem_after[2:0];
                        r_act  <= 1'b0;
                    end else begin
                        r_seg  <= w[SEG_W-1:0];
                        r_rem  <= rem_after;
                        r_pend <= '0;
                        r_cnt  <= '0;
                        r_act  <= 1'b1;
                    end
                end else begin
                    r_pend <= w[SEG_W+7 -: 7];
                    r_cnt  <= sum[2:0];
                    r_act  <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_byte   = r_obyte;
    assign o_out.valid_bits = r_obits;
    assign o_out.last       = r_olast;

    // The active item keeps its queue entry until it finishes
    a_act_holds_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> i_q_valid) else $error("active item without queue entry");

    // A continued item always has at least one more full byte
    a_act_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_rem >= LEN_W'(8))) else $error("active remainder too short");

    // A flush leaves nothing pending
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && cur_flush) |=> (r_cnt == '0)) else $error("pending bits after flush");

    // A partial byte is always the final byte of its item
    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_obits != NBITS_W'(8)) |-> r_olast)
        else $error("partial byte not marked last");

endmodule

@@ hw/rtl/compressed_integer_bit_packer.sv @@
// Top level of the compressed integer bit packer: front, queue and back end.
//
//   channel  dir  payload                          handshake
//   i_in     in   cmd[2:0], value[63:0]            valid/ready
//   o_out    out  out_byte[7:0], valid_bits[3:0],  valid/ready
//                 last
//
// An item produces up to nine bytes in the back end; the back end emits one
// byte per cycle, unless the output stalls, via a single output register.
// The front end classifies in the accept cycle and writes into a queue of
// QUEUE_DEPTH entries, so input accepts continue while the back end drains.
// Reset (i_rst_n low, synchronous) clears pending bits, queue and output.
// An output stall freezes the back end; the input stalls only on a full queue.
module compressed_integer_bit_packer import cibp_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cibp_in_if.snk    i_in,
    cibp_out_if.src   o_out
);

    logic keep, q_full, q_valid, pop;
    t_seg seg, head;

    cibp_front u_front (
        .i_cmd   (i_in.cmd),
        .i_value (i_in.value),
        .o_keep  (keep),
        .o_seg   (seg)
    );

    // Accept whenever the queue has room; drop unused command codes
    assign i_in.ready = !q_full;

    cibp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid && keep),
        .i_seg   (seg),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    cibp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
